### design/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg: Pearson correlation unit, shared types and constants
// Transaction layouts, result status codes and the fixed-point formats of the
// result.
// ----------------------------------------------------------------------------
package pcc_pkg;

   localparam int FIELD_W    = 16;          // sample field width on the bus
   localparam int REQ_DATA_W = 32;          // sample_x, sample_y
   localparam int CORR_W     = 16;          // Q1.15 result
   localparam int STATUS_W   = 2;
   localparam int RSP_DATA_W = 24;          // correlation, status, zero fill

   localparam int FRAC_W     = 15;          // fraction bits of Q1.15
   localparam int QUOT_W     = 2 * FRAC_W + 1;
   localparam int ROOT_W     = FRAC_W + 1;

   localparam logic [ROOT_W-1:0] ROOT_ONE  = ROOT_W'(1) << FRAC_W;
   localparam logic [CORR_W-1:0] CORR_MAX  = {1'b0, {(CORR_W-1){1'b1}}};

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_VAR = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

endpackage

### design/pearson_correlation_unit.sv
// ----------------------------------------------------------------------------
// pearson_correlation_unit: streaming Pearson correlation coefficient
// Accumulates paired Q8.8 samples and, on the pair marked last, returns the
// population correlation in Q1.15 with a status code.
// ----------------------------------------------------------------------------
// Each pair transaction takes the pair and updates the count and linear sums,
// then passes through the shared sample multiplier for x*x, y*y and x*y in
// turn. A pair marked last then runs the finishing sequence on a shift-add
// multiplier (eight products of up to 2*(SAMPLE_BITS+clog2(MAX_SAMPLES+2))
// multiplier bits each, early exit when the remaining multiplier bits are
// zero), a restoring divider for a 31-bit quotient and a 16-bit square root
// before the result is offered. req_tready is low throughout; a result
// waiting on rsp_tready does not block the next pair. Pairs beyond
// MAX_SAMPLES are dropped and the run reports ST_OVERFLOW; a zero variance
// reports ST_ZERO_VAR with correlation 0.
module pearson_correlation_unit #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [15:0] sample_x, [31:16] sample_y
   input  logic [pcc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [15:0] correlation, [17:16] status, [23:18] zero
   output logic [pcc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pcc_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int CW  = $clog2(MAX_SAMPLES + 2);
   localparam int SW  = SB + CW;
   localparam int QW  = 2 * SB + CW - 1;
   localparam int TW  = 2 * SW;
   localparam int PW  = 2 * TW;
   localparam int DCW = $clog2(QUOT_W);

   typedef enum logic [3:0] {
      S_IDLE, S_ACC, S_FIN, S_MUL_LOAD, S_MUL_RUN, S_CHECK, S_DIV, S_SQRT,
      S_RES, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NXX, OP_SXX, OP_NYY, OP_SYY, OP_NXY, OP_SXY, OP_AB, OP_CC
   } op_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [1:0]              phase_ff, phase_in;
   logic signed [SB-1:0]    x_ff, x_in, y_ff, y_in;
   logic                    last_ff, last_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [SW-1:0]           sx_ff, sx_in, sy_ff, sy_in;
   logic [QW-1:0]           sxx_ff, sxx_in, syy_ff, syy_in, sxy_ff, sxy_in;
   logic [PW-1:0]           mc_ff, mc_in, prod_ff, prod_in;
   logic [TW-1:0]           mp_ff, mp_in;
   logic [TW-1:0]           va_ff, va_in, vb_ff, vb_in, vc_ff, vc_in;
   logic [PW-1:0]           d_ff, d_in, rem_ff, rem_in;
   logic                    nlsb_ff, nlsb_in;
   logic [DCW-1:0]          dcnt_ff, dcnt_in;
   logic [QUOT_W-1:0]       quot_ff, quot_in;
   logic [ROOT_W-1:0]       root_ff, root_in, mask_ff, mask_in;
   logic [CORR_W-1:0]       corr_ff, corr_in;
   status_type              stat_ff, stat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic signed [SB-1:0]    x_smp, y_smp;
   logic signed [SB-1:0]    sm_a, sm_b;
   logic signed [2*SB-1:0]  sm_p;
   logic [SW-1:0]           sx_mag, sy_mag;
   logic [QW-1:0]           sxy_mag;
   logic [TW-1:0]           vc_mag, op_a, op_b, sprod;
   logic                    op_neg;
   logic [PW:0]             div_sh;
   logic [ROOT_W-1:0]       cand, root_sat;
   logic [2*ROOT_W-1:0]     cand_sq;

   generate
      if (SB <= FIELD_W) begin : g_narrow
         assign x_smp = req_tdata[SB-1:0];
         assign y_smp = req_tdata[FIELD_W+SB-1:FIELD_W];
      end else begin : g_wide
         assign x_smp = SB'(req_tdata[FIELD_W-1:0]);
         assign y_smp = SB'(req_tdata[2*FIELD_W-1:FIELD_W]);
      end
   endgenerate

   assign sm_a = (phase_ff == 2'd1) ? y_ff : x_ff;
   assign sm_b = (phase_ff == 2'd0) ? x_ff : y_ff;
   assign sm_p = sm_a * sm_b;

   assign sx_mag  = sx_ff[SW-1] ? SW'(-sx_ff) : sx_ff;
   assign sy_mag  = sy_ff[SW-1] ? SW'(-sy_ff) : sy_ff;
   assign sxy_mag = sxy_ff[QW-1] ? QW'(-sxy_ff) : sxy_ff;
   assign vc_mag  = vc_ff[TW-1] ? TW'(-vc_ff) : vc_ff;

   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_neg = 1'b0;
      case (op_ff)
         OP_NXX: begin op_a = TW'(cnt_ff); op_b = TW'(sxx_ff); end
         OP_SXX: begin op_a = TW'(sx_mag); op_b = TW'(sx_mag); end
         OP_NYY: begin op_a = TW'(cnt_ff); op_b = TW'(syy_ff); end
         OP_SYY: begin op_a = TW'(sy_mag); op_b = TW'(sy_mag); end
         OP_NXY: begin
            op_a   = TW'(cnt_ff);
            op_b   = TW'(sxy_mag);
            op_neg = sxy_ff[QW-1];
         end
         OP_SXY: begin
            op_a   = TW'(sx_mag);
            op_b   = TW'(sy_mag);
            op_neg = sx_ff[SW-1] ^ sy_ff[SW-1];
         end
         OP_AB: begin op_a = va_ff; op_b = vb_ff; end
         OP_CC: begin op_a = vc_mag; op_b = vc_mag; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign sprod   = op_neg ? TW'(-prod_ff[TW-1:0]) : prod_ff[TW-1:0];
   assign div_sh  = {rem_ff, (dcnt_ff == DCW'(QUOT_W - 1)) ? nlsb_ff : 1'b0};
   assign cand    = root_ff | mask_ff;
   assign cand_sq = cand * cand;
   assign root_sat = (root_ff > ROOT_ONE) ? ROOT_ONE : root_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sxx_in       = sxx_ff;
      syy_in       = syy_ff;
      sxy_in       = sxy_ff;
      mc_in        = mc_ff;
      mp_in        = mp_ff;
      prod_in      = prod_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      vc_in        = vc_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      nlsb_in      = nlsb_ff;
      dcnt_in      = dcnt_ff;
      quot_in      = quot_ff;
      root_in      = root_ff;
      mask_in      = mask_ff;
      corr_in      = corr_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               x_in    = x_smp;
               y_in    = y_smp;
               last_in = req_tlast;
               if (cnt_ff >= CW'(MAX_SAMPLES)) begin
                  cnt_in   = CW'(MAX_SAMPLES + 1);
                  state_in = req_tlast ? S_FIN : S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + CW'(1);
                  sx_in    = sx_ff + SW'(x_smp);
                  sy_in    = sy_ff + SW'(y_smp);
                  phase_in = 2'd0;
                  state_in = S_ACC;
               end
            end
         end
         S_ACC: begin
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               2'd0:    sxx_in = sxx_ff + QW'(sm_p);
               2'd1:    syy_in = syy_ff + QW'(sm_p);
               default: begin
                  sxy_in   = sxy_ff + QW'(sm_p);
                  state_in = last_ff ? S_FIN : S_IDLE;
               end
            endcase
         end
         S_FIN: begin
            if (cnt_ff > CW'(MAX_SAMPLES)) begin
               corr_in  = '0;
               stat_in  = ST_OVERFLOW;
               state_in = S_DONE;
            end else begin
               op_in    = OP_NXX;
               state_in = S_MUL_LOAD;
            end
         end
         S_MUL_LOAD: begin
            mc_in    = PW'(op_a);
            mp_in    = op_b;
            prod_in  = '0;
            state_in = S_MUL_RUN;
         end
         S_MUL_RUN: begin
            if (mp_ff != '0) begin
               prod_in = prod_ff + (mp_ff[0] ? mc_ff : '0);
               mc_in   = mc_ff << 1;
               mp_in   = mp_ff >> 1;
            end else begin
               state_in = S_MUL_LOAD;
               case (op_ff)
                  OP_NXX: begin va_in = sprod;         op_in = OP_SXX; end
                  OP_SXX: begin va_in = va_ff - sprod; op_in = OP_NYY; end
                  OP_NYY: begin vb_in = sprod;         op_in = OP_SYY; end
                  OP_SYY: begin vb_in = vb_ff - sprod; op_in = OP_NXY; end
                  OP_NXY: begin vc_in = sprod;         op_in = OP_SXY; end
                  OP_SXY: begin
                     vc_in    = vc_ff - sprod;
                     state_in = S_CHECK;
                  end
                  OP_AB: begin
                     d_in  = prod_ff;
                     op_in = OP_CC;
                  end
                  default: begin
                     // numerator is C^2 * 2^30; its top part seeds the remainder
                     rem_in   = prod_ff >> 1;
                     nlsb_in  = prod_ff[0];
                     dcnt_in  = DCW'(QUOT_W - 1);
                     quot_in  = '0;
                     state_in = S_DIV;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (va_ff == '0 || vb_ff == '0) begin
               corr_in  = '0;
               stat_in  = ST_ZERO_VAR;
               state_in = S_DONE;
            end else begin
               op_in    = OP_AB;
               state_in = S_MUL_LOAD;
            end
         end
         S_DIV: begin
            if (div_sh >= {1'b0, d_ff}) begin
               rem_in  = PW'(div_sh - {1'b0, d_ff});
               quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
            end else begin
               rem_in  = div_sh[PW-1:0];
               quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCW'(1);
            if (dcnt_ff == '0) begin
               root_in  = '0;
               mask_in  = {1'b1, {(ROOT_W-1){1'b0}}};
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (cand_sq <= (2*ROOT_W)'(quot_ff)) begin
               root_in = cand;
            end
            mask_in = mask_ff >> 1;
            if (mask_ff[0]) begin
               state_in = S_RES;
            end
         end
         S_RES: begin
            if (vc_ff[TW-1]) begin
               corr_in = CORR_W'(-root_sat);
            end else begin
               corr_in = (root_sat > CORR_MAX) ? CORR_MAX : root_sat;
            end
            stat_in  = ST_OK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({stat_ff, corr_ff});
               cnt_in       = '0;
               sx_in        = '0;
               sy_in        = '0;
               sxx_in       = '0;
               syy_in       = '0;
               sxy_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_NXX;
         phase_ff     <= 2'd0;
         cnt_ff       <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         syy_ff       <= '0;
         sxy_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxx_ff       <= sxx_in;
         syy_ff       <= syy_in;
         sxy_ff       <= sxy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      last_ff     <= last_in;
      mc_ff       <= mc_in;
      mp_ff       <= mp_in;
      prod_ff     <= prod_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      vc_ff       <= vc_in;
      d_ff        <= d_in;
      rem_ff      <= rem_in;
      nlsb_ff     <= nlsb_in;
      dcnt_ff     <= dcnt_in;
      quot_ff     <= quot_in;
      root_ff     <= root_in;
      mask_ff     <= mask_in;
      corr_ff     <= corr_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### verif/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker: scoreboard for the Pearson correlation unit
// Watches both stream channels, keeps its own running sums for the current
// vector pair, works out the expected Q1.15 coefficient and status whenever a
// last pair is accepted, and compares each returned result in order.
// ----------------------------------------------------------------------------
module pcc_checker #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // [15:0] sample_x, [31:16] sample_y
   input  logic [pcc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [15:0] correlation, [17:16] status, [23:18] zero
   input  logic [pcc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             mismatch_count,
   output int                             pending_results,
   output int                             results_checked
);
   import pcc_pkg::*;

   localparam int WIDE_W = 192;

   typedef struct {
      logic [CORR_W-1:0] correlation;
      status_type        status;
   } coefficient_type;

   coefficient_type awaited_coefficients[$];

   int     run_pairs = 0;
   longint total_x = 0, total_y = 0, total_xx = 0, total_yy = 0, total_xy = 0;
   int     failures = 0;
   int     checked = 0;

   function automatic void clear_run();
      run_pairs = 0;
      total_x   = 0;
      total_y   = 0;
      total_xx  = 0;
      total_yy  = 0;
      total_xy  = 0;
   endfunction

   function automatic void absorb_pair(input logic signed [FIELD_W-1:0] x,
                                       input logic signed [FIELD_W-1:0] y);
      longint wx, wy;
      wx = longint'(x);
      wy = longint'(y);
      if (run_pairs >= MAX_SAMPLES) begin
         run_pairs = MAX_SAMPLES + 1;
      end else begin
         run_pairs++;
         total_x  += wx;
         total_y  += wy;
         total_xx += wx * wx;
         total_yy += wy * wy;
         total_xy += wx * wy;
      end
   endfunction

   // r = C / sqrt(A * B); magnitude is the largest q with q^2 * A * B <= 2^30 * C^2
   function automatic coefficient_type coefficient_of_run();
      coefficient_type  result;
      longint           spread_x, spread_y, covariance, n;
      longint unsigned  cov_mag;
      logic [WIDE_W-1:0] spread_product, cov_scaled, trial;
      logic [ROOT_W:0]  root, cand;
      result.correlation = '0;
      result.status      = ST_OK;
      if (run_pairs > MAX_SAMPLES) begin
         result.status = ST_OVERFLOW;
         return result;
      end
      n          = longint'(run_pairs);
      spread_x   = n * total_xx - total_x * total_x;
      spread_y   = n * total_yy - total_y * total_y;
      covariance = n * total_xy - total_x * total_y;
      if (spread_x == 0 || spread_y == 0) begin
         result.status = ST_ZERO_VAR;
         return result;
      end
      cov_mag        = (covariance < 0) ? -covariance : covariance;
      spread_product = WIDE_W'(spread_x) * WIDE_W'(spread_y);
      cov_scaled     = (WIDE_W'(cov_mag) * WIDE_W'(cov_mag)) << (2 * FRAC_W);
      root = '0;
      for (int pos = FRAC_W; pos >= 0; pos--) begin
         cand  = root | ((ROOT_W + 1)'(1) << pos);
         trial = WIDE_W'(cand) * WIDE_W'(cand) * spread_product;
         if (trial <= cov_scaled)
            root = cand;
      end
      if (root > ROOT_ONE)
         root = ROOT_ONE;
      if (covariance < 0)
         result.correlation = CORR_W'((ROOT_W + 1)'(0) - root);
      else if (root > CORR_MAX)
         result.correlation = CORR_MAX;
      else
         result.correlation = CORR_W'(root);
      return result;
   endfunction

   always @(posedge clock) begin
      coefficient_type   expected;
      logic [CORR_W-1:0] got_corr;
      logic [STATUS_W-1:0] got_status;
      if (reset) begin
         clear_run();
         awaited_coefficients.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_corr   = rsp_tdata[CORR_W-1:0];
            got_status = rsp_tdata[CORR_W +: STATUS_W];
            if (awaited_coefficients.size() == 0) begin
               failures++;
               $display("%0t: unexpected result transaction: correlation %0d status %0d",
                        $time, $signed(got_corr), got_status);
            end else begin
               expected = awaited_coefficients.pop_front();
               checked++;
               if (got_corr !== expected.correlation) begin
                  failures++;
                  $display("%0t: correlation mismatch: expected %0d, actual %0d", $time,
                           $signed(expected.correlation), $signed(got_corr));
               end
               if (got_status !== expected.status) begin
                  failures++;
                  $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                           expected.status, got_status);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_pair(req_tdata[FIELD_W-1:0], req_tdata[2*FIELD_W-1:FIELD_W]);
            if (req_tlast) begin
               awaited_coefficients.insert(awaited_coefficients.size(),
                                           coefficient_of_run());
               clear_run();
            end
         end
      end
      mismatch_count  <= failures;
      pending_results <= awaited_coefficients.size();
      results_checked <= checked;
   end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the Pearson correlation unit
// Streams directed and random vector pairs into the unit with random idling on
// both channels, forces one long result stall, and reports the verdict from
// the scoreboard's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
   import pcc_pkg::*;

   localparam int MAX_SAMPLES     = 1024;
   localparam int RANDOM_PAIRS    = 160;
   localparam int CALM_TAIL_PAIRS = 50;
   localparam int PRESSURE_CYCLES = 3000;
   localparam int DRAIN_CYCLES    = 1200;

   // vector content shapes
   localparam int SHAPE_NOISE     = 0;
   localparam int SHAPE_RISING    = 1;
   localparam int SHAPE_FALLING   = 2;
   localparam int SHAPE_FLAT_X    = 3;
   localparam int SHAPE_NARROW    = 4;
   localparam int SHAPE_EXACT     = 5;
   localparam int SHAPE_FLAT_Y    = 6;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic tail_calm   = 1'b0;
   logic pressure_on = 1'b0;
   int   mismatch_count, pending_results, results_checked;
   int   pairs_sent  = 0;
   int   runs_sent   = 0;
   int   sender_calm = 0;

   always #5 clock = ~clock;

   pearson_correlation_unit #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .SAMPLE_BITS(FIELD_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pcc_checker #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic send_pair(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                            input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pairs_sent++;
      if (last)
         runs_sent++;
      if (sender_calm > 0) begin
         sender_calm--;
      end else if (!tail_calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end else if ($urandom_range(0, 99) == 0) begin
         sender_calm = $urandom_range(50, 200);
      end
   endtask

   task automatic send_random_run(input int length, input int shape);
      logic [FIELD_W-1:0] x, y, fixed_x, fixed_y;
      logic               negate;
      fixed_x = FIELD_W'($urandom);
      fixed_y = FIELD_W'($urandom);
      negate  = 1'($urandom_range(0, 1));
      for (int i = 0; i < length; i++) begin
         x = FIELD_W'($urandom);
         y = FIELD_W'($urandom);
         case (shape)
            SHAPE_RISING:  y = x + FIELD_W'($urandom_range(0, 1023)) - FIELD_W'(512);
            SHAPE_FALLING: y = -x + FIELD_W'($urandom_range(0, 4095)) - FIELD_W'(2048);
            SHAPE_FLAT_X:  x = fixed_x;
            SHAPE_FLAT_Y:  y = fixed_y;
            SHAPE_NARROW: begin
               x = FIELD_W'($urandom_range(0, 8)) - FIELD_W'(4);
               y = FIELD_W'($urandom_range(0, 8)) - FIELD_W'(4);
            end
            SHAPE_EXACT:   y = negate ? -x : x;
            default: ;
         endcase
         send_pair(x, y, i == length - 1);
      end
   endtask

   initial begin : result_sink
      int calm_left;
      bit pressure_served;
      calm_left       = 0;
      pressure_served = 1'b0;
      @(posedge clock);
      forever begin
         if (pressure_on && !pressure_served) begin
            rsp_tready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_served = 1'b1;
         end else if (!tail_calm && calm_left == 0 && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 299) == 0)
               calm_left = $urandom_range(100, 400);
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int random_start;
      int length;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // single pair, both extremes: zero variance
      send_pair(16'h7FFF, 16'h8000, 1'b1);
      // identical columns at full scale: saturates at plus one
      send_pair(16'h8000, 16'h8000, 1'b0);
      send_pair(16'h7FFF, 16'h7FFF, 1'b1);
      // mirrored columns: exactly minus one
      send_pair(16'h8000, 16'h7FFF, 1'b0);
      send_pair(16'h7FFF, 16'h8000, 1'b1);
      // constant x
      send_pair(16'h0000, 16'h0000, 1'b0);
      send_pair(16'h0000, 16'h0005, 1'b0);
      send_pair(16'h0000, 16'hFFF9, 1'b1);
      // constant y
      send_pair(16'h0005, 16'h0300, 1'b0);
      send_pair(16'h0009, 16'h0300, 1'b1);
      // small generic vector
      send_pair(16'h0100, 16'h0200, 1'b0);
      send_pair(16'h0200, 16'h0100, 1'b0);
      send_pair(16'h0300, 16'h0300, 1'b0);
      send_pair(16'h0400, 16'h0400, 1'b1);
      // mixed extremes and single-bit values
      send_pair(16'h0100, 16'h0001, 1'b0);
      send_pair(16'hFFFF, 16'h7FFF, 1'b0);
      send_pair(16'h8000, 16'h1234, 1'b0);
      send_pair(16'h7FFF, 16'hFFFF, 1'b1);

      // results held back for a long stretch so the unit fills and stalls
      pressure_on <= 1'b1;
      repeat (12) send_random_run(3, SHAPE_RISING);

      // one pair past the sample limit: count overflow
      send_random_run(MAX_SAMPLES + 1, $urandom_range(SHAPE_NOISE, SHAPE_FLAT_Y));

      random_start = pairs_sent;
      while (pairs_sent - random_start < RANDOM_PAIRS) begin
         if (pairs_sent - random_start >= RANDOM_PAIRS - CALM_TAIL_PAIRS)
            tail_calm <= 1'b1;
         length = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                              : $urandom_range(1, 12);
         send_random_run(length, $urandom_range(SHAPE_NOISE, SHAPE_FLAT_Y));
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d sample pairs in %0d vectors, %0d coefficients compared.",
               pairs_sent, runs_sent, results_checked);
      $display("Included full-scale extremes, plus and minus one, zero variance, "
               , "the sample limit and count overflow, and a long result stall.");
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
